>>> hdl/fhtf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the free hole table.
// No dependencies; used by fhtf_cell and free_hole_table_fit.
package fhtf_pkg;

  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int REQ_BITS    = 17;

  // operation codes
  localparam logic [MODE_BITS-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FIT      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FIND_BEG = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_FIND_END = 3'd4;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

  // controls broadcast to every cell
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 policy;     // 0 best fit, 1 worst fit
    logic                 shift_in;   // open a slot at pos, shift tail right
    logic                 shift_out;  // close slot at pos, shift tail left
  } ctrl_t;

endpackage

>>> hdl/fhtf_cell.sv
`timescale 1ns / 1ps
// One table cell: holds a hole entry and one stage of the scan probe.
// Depends on fhtf_pkg.
module fhtf_cell #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                             clk,
  input  fhtf_pkg::ctrl_t                  ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic [$clog2(DEPTH)-1:0]         pos,
  input  logic [ADDR_BITS-1:0]             key_first,
  input  logic [ADDR_BITS-1:0]             key_last,
  input  logic [fhtf_pkg::REQ_BITS-1:0]    req,
  input  logic [ADDR_BITS-1:0]             left_first,
  input  logic [ADDR_BITS-1:0]             left_last,
  input  logic [ADDR_BITS-1:0]             right_first,
  input  logic [ADDR_BITS-1:0]             right_last,
  input  logic                             in_hit,
  input  logic [$clog2(DEPTH)-1:0]         in_idx,
  input  logic signed [ADDR_BITS:0]        in_span,
  input  logic [ADDR_BITS-1:0]             in_first,
  input  logic [ADDR_BITS-1:0]             in_last,
  output logic                             out_hit,
  output logic [$clog2(DEPTH)-1:0]         out_idx,
  output logic signed [ADDR_BITS:0]        out_span,
  output logic [ADDR_BITS-1:0]             out_first,
  output logic [ADDR_BITS-1:0]             out_last,
  output logic [ADDR_BITS-1:0]             entry_first,
  output logic [ADDR_BITS-1:0]             entry_last
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);
  localparam int CW   = ((ADDR_BITS > fhtf_pkg::REQ_BITS) ? ADDR_BITS : fhtf_pkg::REQ_BITS) + 2;
  localparam logic [CNTW-1:0] MY_CNT = CNTW'(IDX);
  localparam logic [IW-1:0]   MY_IDX = IW'(IDX);

  logic                     valid;
  logic signed [ADDR_BITS:0] span;
  logic signed [ADDR_BITS:0] key_span;
  logic signed [CW-1:0]     span_ext;
  logic signed [CW-1:0]     req_ext;
  logic                     fits;
  logic                     better;
  logic                     take;

  assign valid    = MY_CNT < count;
  assign span     = $signed({1'b0, entry_last}) - $signed({1'b0, entry_first});
  assign key_span = $signed({1'b0, key_last}) - $signed({1'b0, key_first});
  assign span_ext = $signed({{(CW-ADDR_BITS-1){span[ADDR_BITS]}}, span});
  assign req_ext  = $signed({{(CW-fhtf_pkg::REQ_BITS){1'b0}}, req});
  assign fits     = req_ext <= (span_ext + CW'(1));
  assign better   = ctrl.policy ? (span > in_span) : (span < in_span);

  // does this cell replace the incoming probe record
  always_comb begin
    case (ctrl.mode)
      fhtf_pkg::MODE_INSERT:   take = !in_hit && valid && (span > key_span);
      fhtf_pkg::MODE_REMOVE,
      fhtf_pkg::MODE_FIND_BEG: take = !in_hit && valid && (entry_first == key_first);
      fhtf_pkg::MODE_FIND_END: take = !in_hit && valid && (entry_last == key_first);
      fhtf_pkg::MODE_FIT:      take = valid && fits && (!in_hit || better);
      default:                 take = 1'b0;
    endcase
  end

  // probe stage register
  always_ff @(posedge clk) begin
    if (take) begin
      out_hit   <= 1'b1;
      out_idx   <= MY_IDX;
      out_span  <= span;
      out_first <= entry_first;
      out_last  <= entry_last;
    end else begin
      out_hit   <= in_hit;
      out_idx   <= in_idx;
      out_span  <= in_span;
      out_first <= in_first;
      out_last  <= in_last;
    end
  end

  // entry storage, shifted with neighbors on insert and remove
  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      if (MY_IDX == pos) begin
        entry_first <= key_first;
        entry_last  <= key_last;
      end else if (MY_IDX > pos) begin
        entry_first <= left_first;
        entry_last  <= left_last;
      end
    end else if (ctrl.shift_out && (MY_IDX >= pos)) begin
      entry_first <= right_first;
      entry_last  <= right_last;
    end
  end

endmodule

>>> hdl/free_hole_table_fit.sv
`timescale 1ns / 1ps
// Free hole table with best/worst fit search, built as a chain of cells.
// An accepted operation latches its operands, then the probe ripples down the chain one cell
// per cycle and the result is registered (an insert into a full table or a bad mode skips the scan).
// One operation at a time: in_stall stays high until the result is registered; a result held
// by out_stall delays the next. Reset (synchronous, rst high) empties the table, sets best fit.
// Depends on fhtf_pkg and fhtf_cell.
module free_hole_table_fit #(
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fhtf_pkg::MODE_BITS-1:0]     mode,
  input  logic [ADDR_BITS-1:0]               first_addr,
  input  logic [ADDR_BITS-1:0]               last_addr,
  input  logic [fhtf_pkg::REQ_BITS-1:0]      request_size,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fhtf_pkg::STATUS_BITS-1:0]   status,
  output logic [ADDR_BITS-1:0]               hole_first,
  output logic [ADDR_BITS-1:0]               hole_last,
  output logic [$clog2(DEPTH+1)-1:0]         hole_count
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [IW-1:0]   LAST_IDX = IW'(DEPTH-1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  logic [1:0]                        state;
  logic [IW-1:0]                     scan_cnt;
  logic                              policy;
  logic [CNTW-1:0]                   count;
  logic [fhtf_pkg::MODE_BITS-1:0]    mode_q;
  logic [ADDR_BITS-1:0]              first_q;
  logic [ADDR_BITS-1:0]              last_q;
  logic [fhtf_pkg::REQ_BITS-1:0]     req_q;
  logic                              skip_q;
  logic [fhtf_pkg::STATUS_BITS-1:0]  skip_status;
  logic                              in_xfer;
  logic                              finish;
  logic [IW-1:0]                     pos;
  fhtf_pkg::ctrl_t                   ctrl;

  logic [ADDR_BITS-1:0]  ent_first [DEPTH];
  logic [ADDR_BITS-1:0]  ent_last  [DEPTH];
  logic                  p_hit     [DEPTH];
  logic [IW-1:0]         p_idx     [DEPTH];
  logic signed [ADDR_BITS:0] p_span [DEPTH];
  logic [ADDR_BITS-1:0]  p_first   [DEPTH];
  logic [ADDR_BITS-1:0]  p_last    [DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, policy} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      policy <= pwdata[0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign finish   = (state == S_FIN) && !out_valid;

  // insert lands at the first larger span, or at the end
  assign pos = (mode_q == fhtf_pkg::MODE_INSERT && !p_hit[DEPTH-1]) ?
               count[IW-1:0] : p_idx[DEPTH-1];

  always_comb begin
    ctrl.mode      = mode_q;
    ctrl.policy    = policy;
    ctrl.shift_in  = finish && !skip_q && (mode_q == fhtf_pkg::MODE_INSERT);
    ctrl.shift_out = finish && !skip_q && (mode_q == fhtf_pkg::MODE_REMOVE) &&
                     p_hit[DEPTH-1];
  end

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                      c_hit;
    logic [IW-1:0]             c_idx;
    logic signed [ADDR_BITS:0] c_span;
    logic [ADDR_BITS-1:0]      c_first, c_last, l_first, l_last, r_first, r_last;
    if (g == 0) begin : g_head
      assign c_hit   = 1'b0;
      assign c_idx   = '0;
      assign c_span  = '0;
      assign c_first = '0;
      assign c_last  = '0;
      assign l_first = first_q;
      assign l_last  = last_q;
    end else begin : g_body
      assign c_hit   = p_hit[g-1];
      assign c_idx   = p_idx[g-1];
      assign c_span  = p_span[g-1];
      assign c_first = p_first[g-1];
      assign c_last  = p_last[g-1];
      assign l_first = ent_first[g-1];
      assign l_last  = ent_last[g-1];
    end
    if (g == DEPTH-1) begin : g_tail
      assign r_first = ent_first[g];
      assign r_last  = ent_last[g];
    end else begin : g_mid
      assign r_first = ent_first[g+1];
      assign r_last  = ent_last[g+1];
    end
    fhtf_cell #(.DEPTH(DEPTH), .ADDR_BITS(ADDR_BITS), .IDX(g)) u_cell (
      .clk(clk), .ctrl(ctrl), .count(count), .pos(pos),
      .key_first(first_q), .key_last(last_q), .req(req_q),
      .left_first(l_first), .left_last(l_last),
      .right_first(r_first), .right_last(r_last),
      .in_hit(c_hit), .in_idx(c_idx), .in_span(c_span),
      .in_first(c_first), .in_last(c_last),
      .out_hit(p_hit[g]), .out_idx(p_idx[g]), .out_span(p_span[g]),
      .out_first(p_first[g]), .out_last(p_last[g]),
      .entry_first(ent_first[g]), .entry_last(ent_last[g])
    );
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_q  <= mode;
      first_q <= first_addr;
      last_q  <= last_addr;
      req_q   <= request_size;
      if (mode == fhtf_pkg::MODE_INSERT && count == FULL_CNT) begin
        skip_q      <= 1'b1;
        skip_status <= fhtf_pkg::ST_FULL;
      end else if (mode > fhtf_pkg::MODE_FIND_END) begin
        skip_q      <= 1'b1;
        skip_status <= fhtf_pkg::ST_NOT_FOUND;
      end else begin
        skip_q      <= 1'b0;
        skip_status <= fhtf_pkg::ST_NOT_FOUND;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          if (in_xfer) begin
            if ((mode == fhtf_pkg::MODE_INSERT && count == FULL_CNT) ||
                (mode > fhtf_pkg::MODE_FIND_END)) begin
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == LAST_IDX) state <= S_FIN;
        end
        S_FIN: begin
          if (finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (finish) begin
        out_valid  <= 1'b1;
        status     <= fhtf_pkg::ST_NOT_FOUND;
        hole_first <= '0;
        hole_last  <= '0;
        hole_count <= count;
        if (skip_q) begin
          status <= skip_status;
        end else if (mode_q == fhtf_pkg::MODE_INSERT) begin
          status     <= fhtf_pkg::ST_OK;
          hole_first <= first_q;
          hole_last  <= last_q;
          hole_count <= count + CNTW'(1);
          count      <= count + CNTW'(1);
        end else if (p_hit[DEPTH-1]) begin
          status     <= fhtf_pkg::ST_OK;
          hole_first <= p_first[DEPTH-1];
          hole_last  <= p_last[DEPTH-1];
          if (mode_q == fhtf_pkg::MODE_REMOVE) begin
            hole_count <= count - CNTW'(1);
            count      <= count - CNTW'(1);
          end
        end
      end
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("hole count beyond table depth");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == fhtf_pkg::ST_FULL) |-> (hole_count == FULL_CNT))
    else $error("full status with free slots");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && $past(state) == S_SCAN) |-> $stable(count))
    else $error("fill count changed during scan");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != fhtf_pkg::ST_OK) |-> (hole_first == '0 && hole_last == '0))
    else $error("hole fields nonzero on miss");

endmodule
